FILE: rtl/q2e_pkg.sv
// Shared constants and arctangent table for the quaternion to Euler angle pipeline.
// No dependencies.
package q2e_pkg;
  localparam int VW = 66;
  localparam logic signed [VW-1:0] ONE_Q30 = 66'sd1073741824;
  localparam logic signed [VW-1:0] HALF_PI = 66'sd1686629713;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RDFAIL = 2'd1;
  localparam logic [1:0] ST_NOQUAT = 2'd2;

  function automatic logic signed [VW-1:0] atan_tab(input int i);
    logic signed [VW-1:0] r;
    case (i)
      0: r = 66'sd843314856;  1: r = 66'sd497837829;  2: r = 66'sd263043836;
      3: r = 66'sd133525158;  4: r = 66'sd67021686;   5: r = 66'sd33543515;
      6: r = 66'sd16775850;   7: r = 66'sd8388437;    8: r = 66'sd4194282;
      9: r = 66'sd2097149;    10: r = 66'sd1048575;   11: r = 66'sd524287;
      12: r = 66'sd262143;    13: r = 66'sd131071;    14: r = 66'sd65535;
      15: r = 66'sd32767;     16: r = 66'sd16383;     17: r = 66'sd8191;
      18: r = 66'sd4095;      19: r = 66'sd2047;      20: r = 66'sd1023;
      21: r = 66'sd511;       22: r = 66'sd255;       23: r = 66'sd127;
      24: r = 66'sd63;        25: r = 66'sd31;        26: r = 66'sd15;
      27: r = 66'sd8;         28: r = 66'sd4;         29: r = 66'sd2;
      30: r = 66'sd1;         default: r = '0;
    endcase
    return r;
  endfunction
endpackage

FILE: rtl/quaternion_to_euler_angles.sv
// Quaternion to Euler angles, fully pipelined; one beat per cycle while the output does not stall.
// CORDIC_STAGES is capped at 32.
// The pitch cosine comes from a square root that resolves one bit per stage.
// Stall freezes the whole pipe; rst clears the valid bits only.
// Depends on q2e_pkg, q2e_cordic.
module quaternion_to_euler_angles import q2e_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               read_failed,
  input  logic               has_quat,
  input  logic signed [31:0] q_w,
  input  logic signed [31:0] q_x,
  input  logic signed [31:0] q_y,
  input  logic signed [31:0] q_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [14:0] pitch_cdeg,
  output logic signed [15:0] roll_cdeg,
  output logic signed [15:0] yaw_cdeg
);
  localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int SQ = 31;
  localparam int DEPTH = 5 + SQ + 1 + NS + 1 + 2;

  logic en;
  logic [DEPTH-1:0] vld;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], in_valid};
  end

  // status travels alongside
  logic [1:0] st [DEPTH-1];
  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= read_failed ? ST_RDFAIL : (!has_quat ? ST_NOQUAT : ST_OK);
      for (int k = 1; k < DEPTH - 1; k++) st[k] <= st[k-1];
    end
  end

  // stage 1: nine products
  logic signed [63:0] p_wy, p_xz, p_yz, p_wx, p_xx, p_yy, p_xy, p_wz, p_zz;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wy <= q_w * q_y; p_xz <= q_x * q_z; p_yz <= q_y * q_z;
      p_wx <= q_w * q_x; p_xx <= q_x * q_x; p_yy <= q_y * q_y;
      p_xy <= q_x * q_y; p_wz <= q_w * q_z; p_zz <= q_z * q_z;
    end
  end

  function automatic logic signed [VW-1:0] fq(input logic signed [63:0] p);
    return VW'(p >>> 30);
  endfunction

  // stage 2: sums
  logic signed [VW-1:0] s2, rn2, rd2, yn2, yd2;
  always_ff @(posedge clk) begin
    if (en) begin
      s2  <= (fq(p_wy) - fq(p_xz)) <<< 1;
      rn2 <= (fq(p_yz) + fq(p_wx)) <<< 1;
      rd2 <= ONE_Q30 - ((fq(p_xx) + fq(p_yy)) <<< 1);
      yn2 <= (fq(p_xy) + fq(p_wz)) <<< 1;
      yd2 <= ONE_Q30 - ((fq(p_yy) + fq(p_zz)) <<< 1);
    end
  end

  // stage 3: saturate; stage 4: square; stage 5: radicand
  logic signed [31:0] s3, s4, s5;
  logic signed [63:0] sq4;
  logic [60:0] rad5;
  always_ff @(posedge clk) begin
    if (en) begin
      if (s2 > ONE_Q30) s3 <= 32'sh40000000;
      else if (s2 < -ONE_Q30) s3 <= -32'sh40000000;
      else s3 <= 32'(s2);
      s4 <= s3;
      sq4 <= s3 * s3;
      s5 <= s4;
      rad5 <= 61'((64'sd1 << 60) - sq4);
    end
  end

  // delay lines for roll/yaw operands to match square root latency
  localparam int DL = 3 + SQ + 1;
  logic signed [VW-1:0] rn_d [DL], rd_d [DL], yn_d [DL], yd_d [DL];
  always_ff @(posedge clk) begin
    if (en) begin
      rn_d[0] <= rn2; rd_d[0] <= rd2; yn_d[0] <= yn2; yd_d[0] <= yd2;
      for (int k = 1; k < DL; k++) begin
        rn_d[k] <= rn_d[k-1]; rd_d[k] <= rd_d[k-1];
        yn_d[k] <= yn_d[k-1]; yd_d[k] <= yd_d[k-1];
      end
    end
  end

  // square root, one result bit per stage (bits 30..0)
  logic [60:0] rv [SQ+1];
  logic [30:0] rr [SQ+1];
  logic signed [31:0] sd [SQ+1];
  always_comb begin
    rv[0] = rad5; rr[0] = '0; sd[0] = s5;
  end
  for (genvar j = 0; j < SQ; j++) begin : g_sq
    localparam int B = SQ - 1 - j;
    logic [60:0] trial;
    logic [62:0] tw;
    assign tw = ({32'd0, rr[j]} << (B + 1)) + (63'd1 << (2 * B));
    assign trial = tw[60:0];
    logic [60:0] rv_q;
    logic [30:0] rr_q;
    logic signed [31:0] sd_q;
    always_ff @(posedge clk) begin
      if (en) begin
        if (tw[62:61] == 2'b00 && rv[j] >= trial) begin
          rv_q <= rv[j] - trial; rr_q <= rr[j] | (31'd1 << B);
        end else begin
          rv_q <= rv[j]; rr_q <= rr[j];
        end
        sd_q <= sd[j];
      end
    end
    assign rv[j+1] = rv_q; assign rr[j+1] = rr_q; assign sd[j+1] = sd_q;
  end

  logic signed [VW-1:0] px, py;
  always_ff @(posedge clk) begin
    if (en) begin
      px <= VW'({1'b0, rr[SQ]});
      py <= VW'(sd[SQ]);
    end
  end

  logic signed [VW-1:0] zp, zr, zy;
  q2e_cordic #(.STAGES(NS)) u_p (.clk, .en, .x(px), .y(py), .z(zp));
  q2e_cordic #(.STAGES(NS)) u_r (.clk, .en, .x(rd_d[DL-1]), .y(rn_d[DL-1]), .z(zr));
  q2e_cordic #(.STAGES(NS)) u_y (.clk, .en, .x(yd_d[DL-1]), .y(yn_d[DL-1]), .z(zy));

  // scale: two stages (multiply, round)
  logic signed [47:0] mp, mr, my;
  always_ff @(posedge clk) begin
    if (en) begin
      mp <= 48'(zp) * 48'sd5730;
      mr <= 48'(zr) * 48'sd5730;
      my <= 48'(zy) * 48'sd5730;
    end
  end
  logic signed [47:0] rp, rq, ry;
  always_comb begin
    rp = (mp + 48'sd536870912) >>> 30;
    rq = (mr + 48'sd536870912) >>> 30;
    ry = (my + 48'sd536870912) >>> 30;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      status <= st[DEPTH-2];
      if (st[DEPTH-2] == ST_OK) begin
        pitch_cdeg <= 15'(rp); roll_cdeg <= 16'(rq); yaw_cdeg <= 16'(ry);
      end else begin
        pitch_cdeg <= '0; roll_cdeg <= '0; yaw_cdeg <= '0;
      end
    end
  end
endmodule

FILE: rtl/q2e_cordic.sv
// Pipelined vectoring CORDIC: angle of (x, y) in Q30 radians.
// Depends on q2e_pkg. One stage per iteration, advances on en.
module q2e_cordic import q2e_pkg::*; #(
  parameter int STAGES = 24
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [VW-1:0] x,
  input  logic signed [VW-1:0] y,
  output logic signed [VW-1:0] z
);
  logic signed [VW-1:0] xs [STAGES+1];
  logic signed [VW-1:0] ys [STAGES+1];
  logic signed [VW-1:0] zs [STAGES+1];
  logic                 zero [STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x == '0) && (y == '0);
      if (x < 0) begin
        if (y >= 0) begin
          xs[0] <= y; ys[0] <= -x; zs[0] <= HALF_PI;
        end else begin
          xs[0] <= -y; ys[0] <= x; zs[0] <= -HALF_PI;
        end
      end else begin
        xs[0] <= x; ys[0] <= y; zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_tab(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_tab(i);
        end
      end
    end
  end

  assign z = zero[STAGES] ? '0 : zs[STAGES];
endmodule

FILE: rtl/q2e_checker.sv
// Port-level checks for quaternion_to_euler_angles, with bind.
// Depends on q2e_pkg.
module q2e_checker import q2e_pkg::*; (
  input logic clk, input logic rst, input logic in_stall,
  input logic out_valid, input logic out_stall, input logic [1:0] status,
  input logic signed [14:0] pitch_cdeg, input logic signed [15:0] roll_cdeg,
  input logic signed [15:0] yaw_cdeg
);
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> pitch_cdeg == 0 && roll_cdeg == 0 && yaw_cdeg == 0)
    else $error("error beat with angles");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3) else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)) else $error("beat lost");
  a_bp: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall) else $error("spurious stall");
endmodule

bind quaternion_to_euler_angles q2e_checker u_chk (.*);

FILE: test/quaternion_to_euler_angles_tb.sv
// Self-checking testbench for quaternion_to_euler_angles: status and Euler angles
// are predicted by a fixed-point CORDIC model and checked beat by beat.
// Depends on q2e_pkg and the quaternion_to_euler_angles RTL.
`timescale 1ns / 1ps

module quaternion_to_euler_angles_tb;
  import q2e_pkg::*;

  localparam int NSTAGES = 24;
  localparam int NRAND = 600;
  localparam int LATENCY = 40 + NSTAGES;
  localparam longint LIMIT = 400000;
  localparam longint Q1 = 64'sd1073741824;
  localparam longint HPI = 64'sd1686629713;

  typedef struct packed {
    logic [1:0]         st;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
  } angles_t;

  typedef struct {
    logic rf;
    logic hq;
    logic signed [31:0] w, x, y, z;
    logic chk;
    angles_t want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic read_failed = 0, has_quat = 0;
  logic signed [31:0] q_w = 0, q_x = 0, q_y = 0, q_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic signed [14:0] pitch_cdeg;
  logic signed [15:0] roll_cdeg, yaw_cdeg;

  angles_t expected_angles[$];
  int mismatches = 0;
  int beats_out = 0;
  int beats_in = 0;
  longint cycles = 0;
  bit hold_off = 0;
  bit busy_phase = 0;
  bit sending_done = 0;

  quaternion_to_euler_angles #(.CORDIC_STAGES(NSTAGES)) u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic longint asr64(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return asr64(a * b, 30);
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint vec_angle(longint yy, longint xx);
    longint zz, t, dx, dy;
    zz = 0;
    if (xx == 0 && yy == 0) return 0;
    if (xx < 0) begin
      t = xx;
      if (yy >= 0) begin
        xx = yy; yy = -t; zz = HPI;
      end else begin
        xx = -yy; yy = t; zz = -HPI;
      end
    end
    for (int i = 0; i < NSTAGES; i++) begin
      dx = asr64(yy, i);
      dy = asr64(xx, i);
      if (yy >= 0) begin
        xx += dx; yy -= dy; zz += longint'(atan_tab(i));
      end else begin
        xx -= dx; yy += dy; zz -= longint'(atan_tab(i));
      end
    end
    return zz;
  endfunction

  function automatic longint cdeg(longint zz);
    return asr64(zz * 5730 + (Q1 / 2), 30);
  endfunction

  function automatic angles_t euler_from_quat(logic rf, logic hq,
      logic signed [31:0] qw, logic signed [31:0] qx,
      logic signed [31:0] qy, logic signed [31:0] qz);
    angles_t r;
    longint w, x, y, z, s, num, den, c, p, ro, ya;
    r = '0;
    if (rf) begin
      r.st = ST_RDFAIL;
      return r;
    end
    if (!hq) begin
      r.st = ST_NOQUAT;
      return r;
    end
    w = qw; x = qx; y = qy; z = qz;
    s = 2 * (qmul(w, y) - qmul(x, z));
    if (s > Q1) s = Q1;
    if (s < -Q1) s = -Q1;
    c = isqrt((64'd1 << 60) - s * s);
    p = cdeg(vec_angle(s, c));
    num = 2 * (qmul(y, z) + qmul(w, x));
    den = Q1 - 2 * (qmul(x, x) + qmul(y, y));
    ro = cdeg(vec_angle(num, den));
    num = 2 * (qmul(x, y) + qmul(w, z));
    den = Q1 - 2 * (qmul(y, y) + qmul(z, z));
    ya = cdeg(vec_angle(num, den));
    r.st = ST_OK;
    r.pitch = p[14:0];
    r.roll = ro[15:0];
    r.yaw = ya[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h80000000)) - 32'sh40000000;
    endcase
  endfunction

  // directed table: expected typed in for error and identity rows
  row_t dir_rows[$];
  function automatic row_t mk(logic rf, logic hq, logic signed [31:0] w,
      logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
      logic chk, logic [1:0] st);
    row_t r;
    r.rf = rf; r.hq = hq; r.w = w; r.x = x; r.y = y; r.z = z;
    r.chk = chk;
    r.want = '0;
    r.want.st = st;
    return r;
  endfunction

  task automatic send_beat(row_t r);
    angles_t e;
    while (!busy_phase && $urandom_range(0, 99) < 38) begin
      in_valid <= 0;
      @(negedge clk);
    end
    read_failed <= r.rf; has_quat <= r.hq;
    q_w <= r.w; q_x <= r.x; q_y <= r.y; q_z <= r.z;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    e = r.chk ? r.want : euler_from_quat(r.rf, r.hq, r.w, r.x, r.y, r.z);
    expected_angles.push_back(e);
    beats_in++;
    @(negedge clk);
  endtask

  initial begin
    row_t r;
    dir_rows.push_back(mk(1, 1, 32'sh40000000, 0, 0, 0, 1, ST_RDFAIL));
    dir_rows.push_back(mk(1, 0, 32'sh7fffffff, -1, 5, 9, 1, ST_RDFAIL));
    dir_rows.push_back(mk(0, 0, 32'sh40000000, 3, 3, 3, 1, ST_NOQUAT));
    dir_rows.push_back(mk(0, 0, -1, -1, -1, -1, 1, ST_NOQUAT));
    dir_rows.push_back(mk(0, 1, 32'sh40000000, 0, 0, 0, 1, ST_OK));
    dir_rows.push_back(mk(0, 1, 0, 0, 0, 0, 0, ST_OK));
    dir_rows.push_back(mk(0, 1, 32'sh2d413ccd, 0, 32'sh2d413ccd, 0, 0, ST_OK));
    dir_rows.push_back(mk(0, 1, 32'sh2d413ccd, 0, -32'sh2d413ccd, 0, 0, ST_OK));
    dir_rows.push_back(mk(0, 1, 0, 32'sh40000000, 0, 0, 0, ST_OK));
    dir_rows.push_back(mk(0, 1, 0, 0, 0, 32'sh40000000, 0, ST_OK));
    dir_rows.push_back(mk(0, 1, 0, 0, 32'sh40000000, 0, 0, ST_OK));
    dir_rows.push_back(mk(0, 1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh7fffffff, 0, ST_OK));
    dir_rows.push_back(mk(0, 1, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                          32'sh80000000, 0, ST_OK));
    dir_rows.push_back(mk(0, 1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                          32'sh80000000, 0, ST_OK));
    dir_rows.push_back(mk(0, 1, 32'sh2d413ccd, 32'sh2d413ccd, 0, 0, 0, ST_OK));
    dir_rows.push_back(mk(0, 1, 32'sh2d413ccd, -32'sh2d413ccd, 0, 0, 0, ST_OK));
    dir_rows.push_back(mk(0, 1, 32'sh2d413ccd, 0, 0, -32'sh2d413ccd, 0, ST_OK));
    dir_rows.push_back(mk(0, 1, 1, -1, 1, -1, 0, ST_OK));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (dir_rows[i]) send_beat(dir_rows[i]);
    for (int n = 0; n < NRAND; n++) begin
      busy_phase = (n >= 200 && n < 300);
      if (n == 350) hold_off = 1;
      r.rf = ($urandom_range(0, 19) == 0);
      r.hq = ($urandom_range(0, 14) != 0);
      r.w = rand_comp(); r.x = rand_comp(); r.y = rand_comp(); r.z = rand_comp();
      r.chk = 0;
      r.want = '0;
      send_beat(r);
    end
    in_valid <= 0;
    busy_phase = 0;
    sending_done = 1;
  end

  // receiver: random stalls, one long hold-off that back-pressures the sender via in_stall
  initial begin
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      out_stall <= (!busy_phase && $urandom_range(0, 99) < 38);
    end
  end

  always @(posedge clk) begin
    angles_t got, e;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, pitch_cdeg, roll_cdeg, yaw_cdeg};
      beats_out++;
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", got);
      end else begin
        e = expected_angles.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch beat %0d: exp st=%0d p=%0d r=%0d y=%0d",
                      " got st=%0d p=%0d r=%0d y=%0d"},
                     beats_out, e.st, e.pitch, e.roll, e.yaw,
                     got.st, got.pitch, got.roll, got.yaw);
        end
      end
    end
  end

  initial begin
    wait (sending_done && expected_angles.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d quaternions sent (errors, extremes, random), %0d angle sets checked",
             beats_in, beats_out);
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("quaternion_to_euler_angles_tb: done, clean");
    end else begin
      $display("quaternion_to_euler_angles_tb: done, errors");
    end
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("quaternion_to_euler_angles_tb: done, errors");
    $finish;
  end
endmodule
